// File: hw/rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// shared constants, codes and types of the first-fit block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 64;

  localparam int REQ_W  = 12;
  localparam int OFF_W  = 12;
  localparam int STAT_W = 2;

  // table entry field width, table index width, block count width
  localparam int AW   = $clog2(HEAP_BYTES);
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);
  // arithmetic width, room for a sum of a field and a header
  localparam int CW   = ((AW > REQ_W) ? AW : REQ_W) + 2;

  localparam logic [CW-1:0]   HDR_C  = CW'(HEADER_BYTES);
  localparam logic [CNTW-1:0] MAXB_C = CNTW'(MAX_BLOCKS);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMEM  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADOFF = 2'd2;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
    logic          free;
  } entry_t;

  localparam int EW = 2 * AW + 1;

  typedef struct packed {
    logic              done;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  grant;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_NEXT_RD, ST_NEXT_CHK,
    ST_SH_RD, ST_SH_WR, ST_SPLIT_HI, ST_SPLIT_LO, ST_DROP_RD, ST_DROP_WR,
    ST_FINISH
  } state_e;

endpackage
`default_nettype wire

// File: hw/rtl/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// first-fit heap allocator with split on allocate and merge on free
// ----------------------------------------------------------------------------
// each table entry walked takes a read state and a check state, and each entry
//   moved on a split or a merge takes a read state and a write state
// handshake: one word at a time, the next is taken the cycle after the result
//   leaves the sequencer
// reset: after reset the block first writes the single free heap block into
//   the table, then takes words
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator_top import ffa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [REQ_W-1:0]  request_size_i,
  input  wire logic [OFF_W-1:0]  payload_offset_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [STAT_W-1:0]      status_o,
  output logic [OFF_W-1:0]       granted_offset_o
);

  res_t res;
  logic res_ready;
  logic out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q;
  logic [OFF_W-1:0] grant_q;

  // the sequencer may hand over a result once the output register is free or is being read out
  assign res_ready = !out_valid_q || out_ready_i;

  ffa_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .request_size_i   (request_size_i),
    .payload_offset_i (payload_offset_i),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res.done && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  // output word register, valid bit reset only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done && res_ready) begin
      status_q <= res.status;
      grant_q  <= res.grant;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_offset_o = grant_q;

endmodule
`default_nettype wire

// File: hw/rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// sequencer that walks, splits, merges and compacts the block table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffa_ctrl import ffa_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             operation_i,
  input  wire logic [REQ_W-1:0] request_size_i,
  input  wire logic [OFF_W-1:0] payload_offset_i,
  input  wire logic             res_ready_i,
  output res_t                  res_o
);

  state_e state_q, state_d;
  logic op_q, op_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [CNTW-1:0] idx_q, idx_d, cnt_q, cnt_d, k_q, k_d;
  logic [1:0] n_q, n_d;
  logic nxt_ok_q, nxt_ok_d;
  entry_t cur_q, cur_d, prev_q, prev_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [OFF_W-1:0] grant_q, grant_d;

  logic we;
  logic [IW-1:0] waddr, raddr;
  entry_t wdata, e;
  logic [EW-1:0] rdata;

  ffa_ram #(.Width(EW), .Depth(MAX_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign e = entry_t'(rdata);

  logic [CW-1:0] e_size_x, e_start_x, req_x, off_x, cur_size_x, cur_start_x, prev_size_x;
  logic [CNTW:0] kn;
  assign e_size_x    = CW'(e.size);
  assign e_start_x   = CW'(e.start);
  assign req_x       = CW'(req_q);
  assign off_x       = CW'(off_q);
  assign cur_size_x  = CW'(cur_q.size);
  assign cur_start_x = CW'(cur_q.start);
  assign prev_size_x = CW'(prev_q.size);
  assign kn          = (CNTW+1)'(k_q) + (CNTW+1)'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    req_q    <= req_d;
    off_q    <= off_d;
    idx_q    <= idx_d;
    k_q      <= k_d;
    n_q      <= n_d;
    nxt_ok_q <= nxt_ok_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    stat_q   <= stat_d;
    grant_q  <= grant_d;
  end

  always_comb begin
    logic pf, nf;
    state_d  = state_q;
    cnt_d    = cnt_q;
    op_d     = op_q;
    req_d    = req_q;
    off_d    = off_q;
    idx_d    = idx_q;
    k_d      = k_q;
    n_d      = n_q;
    nxt_ok_d = nxt_ok_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    stat_d   = stat_q;
    grant_d  = grant_q;
    we       = 1'b0;
    waddr    = idx_q[IW-1:0];
    wdata    = cur_q;
    raddr    = idx_q[IW-1:0];
    pf       = 1'b0;
    nf       = 1'b0;
    in_ready_o = 1'b0;
    res_o.done   = 1'b0;
    res_o.status = stat_q;
    res_o.grant  = grant_q;

    case (state_q)
      ST_INIT: begin
        // one free block spanning the heap
        we          = 1'b1;
        waddr       = '0;
        wdata.start = '0;
        wdata.size  = AW'(HEAP_BYTES - HEADER_BYTES);
        wdata.free  = 1'b1;
        cnt_d       = CNTW'(1);
        state_d     = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = operation_i;
          req_d   = request_size_i;
          off_d   = payload_offset_i;
          idx_d   = '0;
          grant_d = '0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (idx_q == cnt_q) begin
          stat_d  = (op_q == OP_ALLOC) ? STAT_NOMEM : STAT_BADOFF;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        state_d = ST_SCAN_RD;
        if (op_q == OP_ALLOC) begin
          if (e.free && e_size_x >= req_x) begin
            cur_d   = e;
            state_d = ST_FINISH;
            if (e_size_x == req_x) begin
              we         = 1'b1;
              wdata      = e;
              wdata.free = 1'b0;
              stat_d     = STAT_OK;
              grant_d    = OFF_W'(e_start_x + HDR_C);
            end else if (e_size_x > req_x + HDR_C) begin
              if (cnt_q == MAXB_C) begin
                stat_d = STAT_NOMEM;
              end else begin
                k_d     = cnt_q;
                state_d = ST_SH_RD;
              end
            end else begin
              stat_d = STAT_NOMEM;
            end
          end else begin
            prev_d = e;
            idx_d  = idx_q + 1'b1;
          end
        end else begin
          if (e_start_x + HDR_C == off_x) begin
            cur_d    = e;
            nxt_ok_d = ((CNTW+1)'(idx_q) + 1'b1) < (CNTW+1)'(cnt_q);
            state_d  = ST_NEXT_RD;
          end else begin
            prev_d = e;
            idx_d  = idx_q + 1'b1;
          end
        end
      end
      ST_NEXT_RD: begin
        raddr   = IW'(idx_q + 1'b1);
        state_d = ST_NEXT_CHK;
      end
      ST_NEXT_CHK: begin
        // only the neighbours can be free, the table never holds two free in a row
        pf     = (idx_q != '0) && prev_q.free;
        nf     = nxt_ok_q && e.free;
        stat_d = STAT_OK;
        we     = 1'b1;
        if (pf) begin
          waddr       = IW'(idx_q - 1'b1);
          wdata       = prev_q;
          wdata.size  = nf ? AW'(prev_size_x + HDR_C + cur_size_x + HDR_C + e_size_x)
                           : AW'(prev_size_x + HDR_C + cur_size_x);
          k_d         = idx_q;
          n_d         = nf ? 2'd2 : 2'd1;
          state_d     = ST_DROP_RD;
        end else if (nf) begin
          wdata.size  = AW'(cur_size_x + HDR_C + e_size_x);
          wdata.free  = 1'b1;
          k_d         = idx_q + 1'b1;
          n_d         = 2'd1;
          state_d     = ST_DROP_RD;
        end else begin
          wdata.free  = 1'b1;
          state_d     = ST_FINISH;
        end
      end
      ST_DROP_RD: begin
        if (kn < (CNTW+1)'(cnt_q)) begin
          raddr   = kn[IW-1:0];
          state_d = ST_DROP_WR;
        end else begin
          cnt_d   = cnt_q - CNTW'(n_q);
          state_d = ST_FINISH;
        end
      end
      ST_DROP_WR: begin
        we      = 1'b1;
        waddr   = k_q[IW-1:0];
        wdata   = e;
        k_d     = k_q + 1'b1;
        state_d = ST_DROP_RD;
      end
      ST_SH_RD: begin
        if (k_q == idx_q + 1'b1) begin
          state_d = ST_SPLIT_HI;
        end else begin
          raddr   = IW'(k_q - 1'b1);
          state_d = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        we      = 1'b1;
        waddr   = k_q[IW-1:0];
        wdata   = e;
        k_d     = k_q - 1'b1;
        state_d = ST_SH_RD;
      end
      ST_SPLIT_HI: begin
        we          = 1'b1;
        waddr       = IW'(idx_q + 1'b1);
        wdata.start = AW'(cur_start_x + HDR_C + req_x);
        wdata.size  = AW'(cur_size_x - req_x - HDR_C);
        wdata.free  = 1'b1;
        state_d     = ST_SPLIT_LO;
      end
      ST_SPLIT_LO: begin
        we         = 1'b1;
        wdata.size = AW'(req_x);
        wdata.free = 1'b0;
        cnt_d      = cnt_q + 1'b1;
        stat_d     = STAT_OK;
        grant_d    = OFF_W'(cur_start_x + HDR_C);
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        res_o.done = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffa_checker import ffa_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [STAT_W-1:0] status_o,
  input wire logic [OFF_W-1:0]  granted_offset_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_offset_o))
    else $error("output word changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a word was taken");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK || status_o == STAT_NOMEM
      || status_o == STAT_BADOFF))
    else $error("unknown status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> granted_offset_o == '0)
    else $error("failed request with nonzero offset");

endmodule

bind first_fit_block_allocator_top ffa_checker u_ffa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .granted_offset_o (granted_offset_o)
);
`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench of the first-fit block allocator: directed and random allocate
// and free words, every response checked against a shadow heap table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import ffa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [REQ_W-1:0]  request_size;
  logic [OFF_W-1:0]  payload_offset;
  logic              out_valid;
  logic              out_ready;
  logic [STAT_W-1:0] status;
  logic [OFF_W-1:0]  granted_offset;

  first_fit_block_allocator_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .request_size_i   (request_size),
    .payload_offset_i (payload_offset),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .granted_offset_o (granted_offset)
  );

  // shadow heap table, address ordered
  int unsigned heap_start[MAX_BLOCKS];
  int unsigned heap_size[MAX_BLOCKS];
  bit          heap_free[MAX_BLOCKS];
  int unsigned heap_count;

  // responses still owed by the block
  logic [STAT_W-1:0] owed_status[$];
  logic [OFF_W-1:0]  owed_grant[$];

  // payload offsets granted so far, used to aim frees at real blocks
  int unsigned live_offsets[$];

  int  errors;
  int  words_sent;
  int  words_checked;
  int  idle_cycles;
  bit  sender_paused;
  int  burst_left;
  int  n_nomem;
  int  n_badoff;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic heap_reset();
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      heap_start[k] = 0;
      heap_size[k]  = 0;
      heap_free[k]  = 1'b0;
    end
    heap_size[0] = HEAP_BYTES - HEADER_BYTES;
    heap_free[0] = 1'b1;
    heap_count   = 1;
  endtask

  task automatic heap_remove(int unsigned at);
    for (int unsigned k = at; k + 1 < heap_count; k++) begin
      heap_start[k] = heap_start[k+1];
      heap_size[k]  = heap_size[k+1];
      heap_free[k]  = heap_free[k+1];
    end
    heap_count--;
    heap_start[heap_count] = 0;
    heap_size[heap_count]  = 0;
    heap_free[heap_count]  = 1'b0;
  endtask

  // merge every run of neighboring free blocks
  task automatic heap_merge();
    int unsigned i;
    i = 0;
    while (i + 1 < heap_count) begin
      if (heap_free[i] && heap_free[i+1]) begin
        heap_size[i] += HEADER_BYTES + heap_size[i+1];
        heap_remove(i + 1);
      end else begin
        i++;
      end
    end
  endtask

  task automatic heap_allocate(int unsigned req, output logic [STAT_W-1:0] st,
                               output logic [OFF_W-1:0] grant);
    int unsigned i;
    grant = '0;
    st    = STAT_NOMEM;
    for (i = 0; i < heap_count; i++) begin
      if (heap_free[i] && heap_size[i] >= req) break;
    end
    if (i >= heap_count) return;
    if (heap_size[i] == req) begin
      heap_free[i] = 1'b0;
    end else if (heap_size[i] > req + HEADER_BYTES) begin
      if (heap_count >= MAX_BLOCKS) return;
      for (int unsigned k = heap_count; k > i + 1; k--) begin
        heap_start[k] = heap_start[k-1];
        heap_size[k]  = heap_size[k-1];
        heap_free[k]  = heap_free[k-1];
      end
      heap_start[i+1] = heap_start[i] + HEADER_BYTES + req;
      heap_size[i+1]  = heap_size[i] - req - HEADER_BYTES;
      heap_free[i+1]  = 1'b1;
      heap_count++;
      heap_size[i] = req;
      heap_free[i] = 1'b0;
    end else begin
      // large enough but too small to split: later blocks are not tried
      return;
    end
    st    = STAT_OK;
    grant = OFF_W'(heap_start[i] + HEADER_BYTES);
  endtask

  task automatic heap_release(int unsigned off, output logic [STAT_W-1:0] st);
    st = STAT_BADOFF;
    for (int unsigned i = 0; i < heap_count; i++) begin
      if (heap_start[i] + HEADER_BYTES == off) begin
        heap_free[i] = 1'b1;
        heap_merge();
        st = STAT_OK;
        return;
      end
    end
  endtask

  // send one word and queue the response it should produce
  task automatic send_word(logic op, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
    logic [STAT_W-1:0] st;
    logic [OFF_W-1:0]  grant;
    // sender bursts with random gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
    burst_left--;
    operation      <= op;
    request_size   <= req;
    payload_offset <= off;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    grant = '0;
    if (op == OP_ALLOC) begin
      heap_allocate(req, st, grant);
      if (st == STAT_OK) live_offsets.push_back(grant);
    end else begin
      heap_release(off, st);
    end
    if (st == STAT_NOMEM) n_nomem++;
    if (st == STAT_BADOFF) n_badoff++;
    owed_status.push_back(st);
    owed_grant.push_back(grant);
    words_sent++;
    @(negedge clk);
  endtask

  // free a payload offset that was granted earlier, or noise
  task automatic free_live();
    int unsigned idx;
    if (live_offsets.size() == 0) begin
      send_word(OP_FREE, REQ_W'($urandom), OFF_W'($urandom));
    end else begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      send_word(OP_FREE, REQ_W'($urandom), OFF_W'(live_offsets[idx]));
      live_offsets.delete(idx);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (owed_status.size() != 0) @(negedge clk);
    repeat (4 * MAX_BLOCKS + 16) @(negedge clk);
  endtask

  // allocate and free extremes: zero size, exact fit, too small to split, nothing fits, unknown offsets, merges
  task automatic test_alloc_edges();
    send_word(OP_ALLOC, 12'hfff, 12'h000);                // larger than the heap
    send_word(OP_ALLOC, 12'd0, 12'hfff);                  // empty payload split
    send_word(OP_ALLOC, 12'd100, 12'h000);
    send_word(OP_FREE, 12'h000, 12'd24);                  // free the empty block
    send_word(OP_FREE, 12'h000, 12'd24);                  // free a free block
    send_word(OP_FREE, 12'h000, 12'd0);                   // unknown offset
    send_word(OP_FREE, 12'hfff, 12'hfff);                 // unknown offset
    send_word(OP_FREE, 12'h000, 12'd48);                  // middle block, merges all
    // heap is one free block again: take it whole by exact fit
    send_word(OP_ALLOC, 12'(HEAP_BYTES - HEADER_BYTES), 12'h000);
    send_word(OP_ALLOC, 12'd0, 12'h000);                  // nothing left
    send_word(OP_FREE, 12'h000, 12'd24);
    // leave a free remainder that is neither exact nor splittable
    send_word(OP_ALLOC, 12'(HEAP_BYTES - 2 * HEADER_BYTES - 10), 12'h000);
    send_word(OP_ALLOC, 12'd0, 12'h000);                  // 10 bytes, too small to split
    send_word(OP_ALLOC, 12'd10, 12'h000);                 // exact fit of the rest
    send_word(OP_FREE, 12'h000, 12'd24);
    send_word(OP_FREE, 12'h000, 12'(HEAP_BYTES - 10));
    drain();
    live_offsets.delete();
  endtask

  // fill the table until a split finds no free entry, then release it all
  task automatic test_table_full();
    repeat (MAX_BLOCKS + 2) send_word(OP_ALLOC, 12'd8, 12'h000);
    while (live_offsets.size() != 0) free_live();
    drain();
  endtask

  // mostly matched allocate and free words, with noise frees
  task automatic test_random_traffic();
    int unsigned pick;
    for (int n = 0; n < 1600; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 9) == 0) send_word(OP_ALLOC, REQ_W'($urandom), OFF_W'($urandom));
        else send_word(OP_ALLOC, REQ_W'($urandom_range(0, 200)), OFF_W'($urandom));
      end else if (pick < 88) begin
        free_live();
      end else begin
        send_word(OP_FREE, REQ_W'($urandom), OFF_W'($urandom));
      end
    end
    drain();
  endtask

  // response checker against the queue of owed responses
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (owed_status.size() == 0) begin
        $display("%0t: response with none owed, actual status %0d offset %0d",
                 $time, status, granted_offset);
        errors++;
      end else begin
        if (status !== owed_status[0]) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, owed_status[0], status);
          errors++;
        end
        if (granted_offset !== owed_grant[0]) begin
          $display("%0t: granted offset mismatch, expected %0d actual %0d",
                   $time, owed_grant[0], granted_offset);
          errors++;
        end
        void'(owed_status.pop_front());
        void'(owed_grant.pop_front());
        words_checked++;
      end
    end
  end

  // receiver stalls in phases: some stretches always ready
  int stall_phase;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9:8] == 2'd0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    out_ready      = 1'b0;
    operation      = OP_ALLOC;
    request_size   = '0;
    payload_offset = '0;
    errors         = 0;
    words_sent     = 0;
    words_checked  = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    stall_phase    = 0;
    n_nomem        = 0;
    n_badoff       = 0;
    heap_reset();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_alloc_edges();
    test_table_full();
    test_random_traffic();
    $display("sent %0d words, checked %0d responses", words_sent, words_checked);
    $display("out-of-memory responses %0d, bad offset responses %0d", n_nomem, n_badoff);
    if (errors == 0 && owed_status.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
